[rtl/pvfd_pkg.sv]
// Shared types, constants and helpers for the prefix varint field decoder.
// No dependencies; used by pvfd_step and prefix_varint_field_decoder.
package pvfd_pkg;

	// Result status codes
	typedef enum logic [1:0] {
		ST_OK          = 2'd0,
		ST_ZERO_PREFIX = 2'd1,
		ST_TRUNCATED   = 2'd2
	} status_t;

	// Input beat: one byte of the coded buffer
	typedef struct packed {
		logic [7:0] byte_value;
		logic       buffer_last;
	} in_beat_t;

	// Output beat: one decoded field or one error
	typedef struct packed {
		logic [31:0] value_high;
		logic [63:0] value_low;
		logic [6:0]  bit_length;
		logic [3:0]  byte_length;
		status_t     status;
	} out_beat_t;

	// Field parse state carried from byte to byte
	typedef struct packed {
		logic        in_field;
		logic [3:0]  bytes_left;
		logic [3:0]  field_size;
		logic [31:0] acc_hi;
		logic [63:0] acc_lo;
		logic [6:0]  acc_bits;   // running bit length of acc_hi:acc_lo
	} field_state_t;

	// Result of one decode step
	typedef struct packed {
		logic      emit;
		out_beat_t beat;
	} step_res_t;

	// Field length in bytes, indexed by the count of leading zero bits of the prefix byte
	localparam logic [3:0] LEN_TABLE [8] = '{
		4'd1, 4'd2, 4'd3, 4'd4, 4'd6, 4'd8, 4'd10, 4'd13
	};

	localparam logic [6:0] BYTE_BITS = 7'd8;

	// Position of highest set bit plus one, 0 for zero
	function automatic logic [3:0] bit_len8(input logic [7:0] v);
		logic [3:0] n;
		n = '0;
		for (int i = 0; i < 8; i++) begin
			if (v[i]) begin
				n = 4'(i + 1);
			end
		end
		return n;
	endfunction

endpackage

[rtl/pvfd_step.sv]
// Combinational decode of one byte against the current field state.
// Depends on pvfd_pkg.
module pvfd_step (
	input  pvfd_pkg::field_state_t cur,
	input  pvfd_pkg::in_beat_t     beat,
	output pvfd_pkg::field_state_t nxt,
	output pvfd_pkg::step_res_t    res
);

	logic [7:0]  b;
	logic [3:0]  nb;
	logic [2:0]  pos;
	logic [7:0]  payload;
	logic [3:0]  pay_bits;
	logic [3:0]  size;
	logic [3:0]  left;
	logic [31:0] sh_hi;
	logic [63:0] sh_lo;
	logic [6:0]  sh_bits;

	// Prefix byte decode
	always_comb begin
		b        = beat.byte_value;
		nb       = pvfd_pkg::bit_len8(b);
		pos      = 3'(nb - 4'd1);
		payload  = b & ~(8'd1 << pos);
		pay_bits = pvfd_pkg::bit_len8(payload);
		size     = pvfd_pkg::LEN_TABLE[3'(4'd8 - nb)];
	end

	// Continuation byte: shift in big-endian, track bit length incrementally
	always_comb begin
		sh_hi   = {cur.acc_hi[23:0], cur.acc_lo[63:56]};
		sh_lo   = {cur.acc_lo[55:0], b};
		sh_bits = (cur.acc_bits != '0) ? cur.acc_bits + pvfd_pkg::BYTE_BITS
		                               : 7'(pvfd_pkg::bit_len8(b));
		left    = cur.bytes_left - 4'd1;
	end

	// Next state and result
	always_comb begin
		nxt  = '0;
		res  = '0;
		res.beat.status = pvfd_pkg::ST_OK;
		if (!cur.in_field) begin
			if (b == 8'd0) begin
				res.emit             = 1'b1;
				res.beat.byte_length = 4'd1;
				res.beat.status      = pvfd_pkg::ST_ZERO_PREFIX;
			end else if (size == 4'd1) begin
				res.emit             = 1'b1;
				res.beat.value_low   = {56'd0, payload};
				res.beat.bit_length  = 7'(pay_bits);
				res.beat.byte_length = 4'd1;
			end else if (beat.buffer_last) begin
				res.emit             = 1'b1;
				res.beat.byte_length = 4'd1;
				res.beat.status      = pvfd_pkg::ST_TRUNCATED;
			end else begin
				nxt.in_field   = 1'b1;
				nxt.bytes_left = size - 4'd1;
				nxt.field_size = size;
				nxt.acc_lo     = {56'd0, payload};
				nxt.acc_bits   = 7'(pay_bits);
			end
		end else begin
			if (left == 4'd0) begin
				res.emit             = 1'b1;
				res.beat.value_high  = sh_hi;
				res.beat.value_low   = sh_lo;
				res.beat.bit_length  = sh_bits;
				res.beat.byte_length = cur.field_size;
			end else if (beat.buffer_last) begin
				res.emit             = 1'b1;
				res.beat.byte_length = cur.field_size - left;
				res.beat.status      = pvfd_pkg::ST_TRUNCATED;
			end else begin
				nxt.in_field   = 1'b1;
				nxt.bytes_left = left;
				nxt.field_size = cur.field_size;
				nxt.acc_hi     = sh_hi;
				nxt.acc_lo     = sh_lo;
				nxt.acc_bits   = sh_bits;
			end
		end
	end

endmodule

[rtl/prefix_varint_field_decoder.sv]
// Top level of the prefix-length varint field decoder.
// Depends on pvfd_pkg and pvfd_step.
//
// Usage:
//   in_valid/in_ready/in_data carry one byte of the coded buffer per beat,
//   with buffer_last marking the final byte of a buffer. out_valid/out_ready/
//   out_data carry one result per completed field or per error: the value
//   (96 bits as value_high:value_low), its bit length, the bytes consumed
//   and a status (ok, zero prefix byte, buffer ended inside a field).
//   Bytes that neither finish a field nor fail produce no result beat.
// Timing:
//   One byte per cycle while the input is not stalled. A byte is registered
//   at acceptance, then decoded against the field state in the next cycle;
//   the result beat goes to the output register, which drives out_valid.
//   The field accumulator updates once per byte, which sets the rate.
// Reset:
//   arst_n clears the input stage, the field state and out_valid; the block
//   then waits for a prefix byte.
// Back-pressure:
//   The output register holds a result while out_ready is low; the input
//   stage keeps taking bytes that emit nothing, and stalls only when a byte
//   that emits a result finds the output register still occupied.
module prefix_varint_field_decoder (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_ready,
	input  pvfd_pkg::in_beat_t  in_data,
	output logic                out_valid,
	input  logic                out_ready,
	output pvfd_pkg::out_beat_t out_data
);

	logic                   valid_s1;
	pvfd_pkg::in_beat_t     beat_s1;
	pvfd_pkg::field_state_t state_q;
	pvfd_pkg::field_state_t state_nxt;
	pvfd_pkg::step_res_t    step_res;
	logic                   out_valid_q;
	pvfd_pkg::out_beat_t    out_data_q;
	logic                   out_free;
	logic                   adv_s1;

	pvfd_step u_step (
		.cur  (state_q),
		.beat (beat_s1),
		.nxt  (state_nxt),
		.res  (step_res)
	);

	// Stage advance: stall only when a result has nowhere to go
	always_comb begin
		out_free = !out_valid_q || out_ready;
		adv_s1   = valid_s1 && (!step_res.emit || out_free);
		in_ready = !valid_s1 || adv_s1;
	end

	// Input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			beat_s1 <= in_data;
		end
	end

	// Field state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= '0;
		end else if (adv_s1) begin
			state_q <= state_nxt;
		end
	end

	// Result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (adv_s1 && step_res.emit) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (adv_s1 && step_res.emit) begin
			out_data_q <= step_res.beat;
		end
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_data_q;

endmodule
